// ----- sv/swbsg_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding window best score group: shared package
// Field widths, default sizes, register indexes and the queued item type.
// ----------------------------------------------------------------------------
package swbsg_pkg;

  localparam int POS_W   = 32;
  localparam int SCORE_W = 32;
  localparam int SUM_W   = 48;
  localparam int SPAN_W  = 31;
  localparam int MINC_W  = 17;
  localparam int FIRST_W = 16;
  localparam int END_W   = 17;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SPAN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT   = 1'd1;

  localparam logic [SPAN_W-1:0] WINDOW_SPAN_RST = 31'd1000;
  localparam logic [MINC_W-1:0] MIN_COUNT_RST   = 17'd3;

  localparam int WINDOW_DEPTH_DEF = 256;
  localparam int MAX_ITEMS_DEF    = 65536;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic [SCORE_W-1:0]      score;
    logic                    last_item;
    logic                    active;
  } item_t;

endpackage

// ----- sv/sliding_window_best_score_group_top.sv -----
// An item is registered into the queue when accepted and is offered to the back end from the queue head.
// The back end stores the item, then drops expired window entries one at a time and
// closes the item; closing the last item waits while the output is stalled.
// A result is registered on the cycle after the last item closes.
// Reset is synchronous and clears all control state; the window store is not cleared.
// ----------------------------------------------------------------------------
// Sliding window best score group: top level
// Holds the configuration registers and joins the front end and back end.
// ----------------------------------------------------------------------------
module sliding_window_best_score_group_top #(
  parameter int WINDOW_DEPTH = swbsg_pkg::WINDOW_DEPTH_DEF,
  parameter int MAX_ITEMS    = swbsg_pkg::MAX_ITEMS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [swbsg_pkg::POS_W-1:0]   in_position,
  input  logic [swbsg_pkg::SCORE_W-1:0]        in_score,
  input  logic                                 in_last_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [swbsg_pkg::FIRST_W-1:0]        out_range_first,
  output logic [swbsg_pkg::END_W-1:0]          out_range_end,
  output logic [swbsg_pkg::SUM_W-1:0]          out_best_sum,
  output logic                                 out_accepted,
  output logic                                 out_overflowed,
  input  logic                                 cfg_we,
  input  logic [swbsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swbsg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_ITEMS + 1);

  logic [swbsg_pkg::SPAN_W-1:0] window_span_r;
  logic [swbsg_pkg::MINC_W-1:0] min_count_r;
  logic                         q_valid, q_pop;
  swbsg_pkg::item_t             q_item;
  logic [IDX_W-1:0]             q_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_span_r <= swbsg_pkg::WINDOW_SPAN_RST;
      min_count_r   <= swbsg_pkg::MIN_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        swbsg_pkg::REG_WINDOW_SPAN: window_span_r <= cfg_wdata[swbsg_pkg::SPAN_W-1:0];
        swbsg_pkg::REG_MIN_COUNT:   min_count_r   <= cfg_wdata[swbsg_pkg::MINC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  swbsg_front #(
    .MAX_ITEMS (MAX_ITEMS),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_position  (in_position),
    .in_score     (in_score),
    .in_last_item (in_last_item),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_idx        (q_idx),
    .q_pop        (q_pop)
  );

  swbsg_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MAX_ITEMS    (MAX_ITEMS),
    .IDX_W        (IDX_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_idx           (q_idx),
    .q_pop           (q_pop),
    .window_span     (window_span_r),
    .min_count       (min_count_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_range_first (out_range_first),
    .out_range_end   (out_range_end),
    .out_best_sum    (out_best_sum),
    .out_accepted    (out_accepted),
    .out_overflowed  (out_overflowed)
  );

endmodule

// ----- sv/swbsg_front.sv -----
// ----------------------------------------------------------------------------
// Sliding window best score group: front end
// Accepts items, numbers and classifies them, and holds them in a short queue.
// ----------------------------------------------------------------------------
module swbsg_front #(
  parameter int MAX_ITEMS = swbsg_pkg::MAX_ITEMS_DEF,
  parameter int IDX_W     = $clog2(MAX_ITEMS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [swbsg_pkg::POS_W-1:0]  in_position,
  input  logic [swbsg_pkg::SCORE_W-1:0]       in_score,
  input  logic                                in_last_item,
  output logic                                q_valid,
  output swbsg_pkg::item_t                    q_item,
  output logic [IDX_W-1:0]                    q_idx,
  input  logic                                q_pop
);

  swbsg_pkg::item_t  q_item_r [2];
  logic [IDX_W-1:0]  q_idx_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        q_cnt_r;
  logic [IDX_W-1:0]  item_cnt_r;
  logic              push, pop, active;

  assign in_stall = (q_cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign active   = (item_cnt_r < IDX_W'(MAX_ITEMS));

  assign q_valid = (q_cnt_r != 2'd0);
  assign q_item  = q_item_r[rd_ptr_r];
  assign q_idx   = q_idx_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      q_cnt_r    <= 2'd0;
      item_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
        if (in_last_item) begin
          item_cnt_r <= '0;
        end else if (active) begin
          item_cnt_r <= item_cnt_r + 1'b1;
        end
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        q_cnt_r <= q_cnt_r + 2'd1;
      end else if (pop && !push) begin
        q_cnt_r <= q_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_item_r[wr_ptr_r] <= '{position: in_position, score: in_score,
                              last_item: in_last_item, active: active};
      q_idx_r[wr_ptr_r]  <= item_cnt_r;
    end
  end

endmodule

// ----- sv/swbsg_back.sv -----
// ----------------------------------------------------------------------------
// Sliding window best score group: back end
// Keeps the window store and running sum, drops old entries one per cycle,
// tracks the best range and registers the result transaction.
// ----------------------------------------------------------------------------
module swbsg_back #(
  parameter int WINDOW_DEPTH = swbsg_pkg::WINDOW_DEPTH_DEF,
  parameter int MAX_ITEMS    = swbsg_pkg::MAX_ITEMS_DEF,
  parameter int IDX_W        = $clog2(MAX_ITEMS + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  swbsg_pkg::item_t                   q_item,
  input  logic [IDX_W-1:0]                   q_idx,
  output logic                               q_pop,
  input  logic [swbsg_pkg::SPAN_W-1:0]       window_span,
  input  logic [swbsg_pkg::MINC_W-1:0]       min_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [swbsg_pkg::FIRST_W-1:0]      out_range_first,
  output logic [swbsg_pkg::END_W-1:0]        out_range_end,
  output logic [swbsg_pkg::SUM_W-1:0]        out_best_sum,
  output logic                               out_accepted,
  output logic                               out_overflowed
);

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W = (IDX_W > swbsg_pkg::MINC_W) ? IDX_W : swbsg_pkg::MINC_W;
  localparam int SUM_W = swbsg_pkg::SUM_W;

  typedef enum logic {ST_TAKE, ST_SCAN} state_t;

  logic signed [swbsg_pkg::POS_W-1:0] mem_pos [WINDOW_DEPTH];
  logic [swbsg_pkg::SCORE_W-1:0]      mem_score [WINDOW_DEPTH];
  logic signed [swbsg_pkg::POS_W-1:0] rd_pos_r;
  logic [swbsg_pkg::SCORE_W-1:0]      rd_score_r;
  logic                               mem_we;

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   start_r, start_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               best_valid_r, best_valid_nxt;
  logic [SUM_W-1:0]   best_sum_r, best_sum_nxt;
  logic [IDX_W-1:0]   best_first_r, best_first_nxt;
  logic [IDX_W-1:0]   best_end_r, best_end_nxt;
  logic               ovf_r, ovf_nxt;
  logic signed [swbsg_pkg::POS_W-1:0] cur_pos_r, cur_pos_nxt;
  logic               cur_last_r, cur_last_nxt;
  logic [IDX_W-1:0]   cur_idx_r, cur_idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [swbsg_pkg::FIRST_W-1:0] out_first_r, out_first_nxt;
  logic [swbsg_pkg::END_W-1:0]   out_end_r, out_end_nxt;
  logic [SUM_W-1:0]   out_sum_r, out_sum_nxt;
  logic               out_acc_r, out_acc_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    logic               can_emit, emit, clear, drop, better;
    logic signed [swbsg_pkg::POS_W:0] pos_gap;
    logic [IDX_W-1:0]   e_first, e_end, len;
    logic [SUM_W-1:0]   e_sum;

    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    start_nxt      = start_r;
    sum_nxt        = sum_r;
    best_valid_nxt = best_valid_r;
    best_sum_nxt   = best_sum_r;
    best_first_nxt = best_first_r;
    best_end_nxt   = best_end_r;
    ovf_nxt        = ovf_r;
    cur_pos_nxt    = cur_pos_r;
    cur_last_nxt   = cur_last_r;
    cur_idx_nxt    = cur_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_first_nxt  = out_first_r;
    out_end_nxt    = out_end_r;
    out_sum_nxt    = out_sum_r;
    out_acc_nxt    = out_acc_r;
    out_ovf_nxt    = out_ovf_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    emit           = 1'b0;
    clear          = 1'b0;
    can_emit       = !out_valid_r || !out_stall;
    e_first        = best_first_r;
    e_end          = best_end_r;
    e_sum          = best_sum_r;
    pos_gap = {cur_pos_r[swbsg_pkg::POS_W-1], cur_pos_r}
            - {rd_pos_r[swbsg_pkg::POS_W-1], rd_pos_r};
    drop = (count_r > CNT_W'(1)) && (pos_gap > $signed({2'b00, window_span}));
    better = !best_valid_r || (sum_r > best_sum_r);

    case (state_r)
      ST_TAKE: begin
        if (q_valid) begin
          if (!q_item.active) begin
            if (!q_item.last_item) begin
              q_pop = 1'b1;
            end else if (can_emit) begin
              q_pop = 1'b1;
              emit  = 1'b1;
              clear = 1'b1;
            end
          end else begin
            q_pop        = 1'b1;
            mem_we       = 1'b1;
            tail_nxt     = ptr_inc(tail_r);
            cur_pos_nxt  = q_item.position;
            cur_last_nxt = q_item.last_item;
            cur_idx_nxt  = q_idx;
            state_nxt    = ST_SCAN;
            if (count_r == CNT_W'(WINDOW_DEPTH)) begin
              head_nxt  = ptr_inc(head_r);
              start_nxt = start_r + 1'b1;
              ovf_nxt   = 1'b1;
              sum_nxt   = sum_r - SUM_W'(rd_score_r) + SUM_W'(q_item.score);
            end else begin
              count_nxt = count_r + 1'b1;
              sum_nxt   = sum_r + SUM_W'(q_item.score);
            end
          end
        end
      end
      ST_SCAN: begin
        if (drop) begin
          head_nxt  = ptr_inc(head_r);
          count_nxt = count_r - 1'b1;
          start_nxt = start_r + 1'b1;
          sum_nxt   = sum_r - SUM_W'(rd_score_r);
        end else if (!cur_last_r || can_emit) begin
          if (better) begin
            best_valid_nxt = 1'b1;
            best_sum_nxt   = sum_r;
            best_first_nxt = start_r;
            best_end_nxt   = cur_idx_r + 1'b1;
            e_first        = start_r;
            e_end          = cur_idx_r + 1'b1;
            e_sum          = sum_r;
          end
          emit      = cur_last_r;
          clear     = cur_last_r;
          state_nxt = ST_TAKE;
        end
      end
      default: begin
        state_nxt = ST_TAKE;
      end
    endcase

    len = (e_end >= e_first) ? (e_end - e_first) : '0;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_first_nxt = swbsg_pkg::FIRST_W'(e_first);
      out_end_nxt   = swbsg_pkg::END_W'(e_end);
      out_sum_nxt   = e_sum;
      out_acc_nxt   = (CMP_W'(len) >= CMP_W'(min_count));
      out_ovf_nxt   = ovf_r;
    end
    if (clear) begin
      head_nxt       = '0;
      tail_nxt       = '0;
      count_nxt      = '0;
      start_nxt      = '0;
      sum_nxt        = '0;
      best_valid_nxt = 1'b0;
      best_sum_nxt   = '0;
      best_first_nxt = '0;
      best_end_nxt   = '0;
      ovf_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_pos[tail_r]   <= q_item.position;
      mem_score[tail_r] <= q_item.score;
    end
    rd_pos_r   <= mem_pos[head_nxt];
    rd_score_r <= mem_score[head_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_TAKE;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      start_r      <= '0;
      sum_r        <= '0;
      best_valid_r <= 1'b0;
      best_sum_r   <= '0;
      best_first_r <= '0;
      best_end_r   <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      start_r      <= start_nxt;
      sum_r        <= sum_nxt;
      best_valid_r <= best_valid_nxt;
      best_sum_r   <= best_sum_nxt;
      best_first_r <= best_first_nxt;
      best_end_r   <= best_end_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cur_pos_r   <= cur_pos_nxt;
    cur_last_r  <= cur_last_nxt;
    cur_idx_r   <= cur_idx_nxt;
    out_first_r <= out_first_nxt;
    out_end_r   <= out_end_nxt;
    out_sum_r   <= out_sum_nxt;
    out_acc_r   <= out_acc_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_range_first = out_first_r;
  assign out_range_end   = out_end_r;
  assign out_best_sum    = out_sum_r;
  assign out_accepted    = out_acc_r;
  assign out_overflowed  = out_ovf_r;

endmodule
